// ===== sv/assert_macros.svh =====
// Assertion macros shared by the merge RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent that implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/kwm_pkg.sv =====
// Package with the types, codes and sizes of the descending merge.
`default_nettype none

package kwm_pkg;

  localparam int MAX_LISTS  = 16;
  localparam int VALUE_BITS = 31;
  localparam int SRC_W      = 4;
  localparam int IDX_W      = $clog2(MAX_LISTS);
  localparam int CNT_W      = $clog2(MAX_LISTS + 1);

  // Item opcodes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_REFILL = 1'b1;

  // Register index of list_count.
  localparam logic REG_LIST_COUNT = 1'b0;

  // One stored head: its value and the list it came from.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [SRC_W-1:0]      src;
  } head_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LSCAN,
    ST_LPUT,
    ST_RSCAN,
    ST_RPUT,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== sv/kway_descending_merge.sv =====
// Top level of the descending merge: head memory, insertion sequencer, output register.
// A load into an empty array or a refill of a lone head writes in idle; a refill after done
// writes nothing. Other loads scan toward the top past the heads they move, other refills away
// from it past the heads they sink below. Results leave via the emit state, held while the
// output is full. Throughput: one head memory read and one write per cycle pace the scan.
// Reset (synchronous) clears the count, the phase and the output; list_count returns to 16.
`default_nettype none
`include "assert_macros.svh"

module kway_descending_merge
  import kwm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  opcode,
  input  wire logic [SRC_W-1:0]      list_number,
  input  wire logic [VALUE_BITS-1:0] posting,
  // Output channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VALUE_BITS-1:0]      merged_value,
  output logic [SRC_W-1:0]           source_list,
  output logic                       done_res,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Configuration register.
  logic [CNT_W-1:0] list_count;
  logic [CNT_W-1:0] eff_count;

  // Control state.
  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             merging, merging_next;
  logic [IDX_W-1:0] pos, pos_next;
  head_t            item, item_next;
  head_t            top;

  // Head memory ports.
  head_t            mem [MAX_LISTS];
  head_t            rdata;
  logic [IDX_W-1:0] raddr;
  logic             mem_we;
  logic [IDX_W-1:0] waddr;
  head_t            wdata;

  // Output register load.
  logic             out_load;
  logic             in_fire;

  // APB register access; the port never stalls.
  assign pready = 1'b1;
  assign prdata = {{(32 - CNT_W){1'b0}}, list_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      list_count <= CNT_W'(MAX_LISTS);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LIST_COUNT)) begin
      list_count <= pwdata[CNT_W-1:0];
    end
  end

  // Clamp the list count to the supported range.
  always_comb begin
    if (list_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (list_count > CNT_W'(MAX_LISTS)) begin
      eff_count = CNT_W'(MAX_LISTS);
    end else begin
      eff_count = list_count;
    end
  end

  // Head memory with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Copy of entry 0, refreshed on every write to it.
  always_ff @(posedge clk) begin
    if (mem_we && (waddr == '0)) begin
      top <= wdata;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Sequencer: load insertion scans toward the top, refill scans away from it.
  always_comb begin
    logic [CNT_W-1:0] base;
    base         = merging ? '0 : cnt;
    state_next   = state;
    cnt_next     = cnt;
    merging_next = merging;
    pos_next     = pos;
    item_next    = item;
    raddr        = '0;
    mem_we       = 1'b0;
    waddr        = '0;
    wdata        = item;
    out_load     = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (opcode == OP_LOAD) begin
            merging_next    = 1'b0;
            cnt_next        = base;
            item_next.value = posting;
            item_next.src   = list_number;
            if (base >= CNT_W'(MAX_LISTS)) begin
              // Full array: the load is dropped, but it still closes the set.
              if (base >= eff_count) begin
                merging_next = 1'b1;
                state_next   = ST_EMIT;
              end
            end else if (base == '0) begin
              mem_we      = 1'b1;
              waddr       = '0;
              wdata.value = posting;
              wdata.src   = list_number;
              cnt_next    = CNT_W'(1);
              if (CNT_W'(1) >= eff_count) begin
                merging_next = 1'b1;
                state_next   = ST_EMIT;
              end
            end else begin
              raddr      = IDX_W'(base - CNT_W'(1));
              pos_next   = IDX_W'(base);
              state_next = ST_LSCAN;
            end
          end else if (merging) begin
            if (top.value == '0) begin
              // Every list is exhausted: repeat the done result.
              state_next = ST_EMIT;
            end else begin
              item_next.value = posting;
              item_next.src   = top.src;
              pos_next        = '0;
              if (cnt >= CNT_W'(2)) begin
                raddr      = IDX_W'(1);
                state_next = ST_RSCAN;
              end else begin
                mem_we      = 1'b1;
                waddr       = '0;
                wdata.value = posting;
                wdata.src   = top.src;
                state_next  = ST_EMIT;
              end
            end
          end
        end
      end

      ST_LSCAN: begin
        // rdata holds the entry just above pos.
        mem_we = 1'b1;
        waddr  = pos;
        if ((rdata.value > item.value) ||
            ((rdata.value == item.value) && (rdata.src <= item.src))) begin
          wdata    = item;
          cnt_next = cnt + CNT_W'(1);
          if ((cnt + CNT_W'(1)) >= eff_count) begin
            merging_next = 1'b1;
            state_next   = ST_EMIT;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          wdata    = rdata;
          pos_next = pos - IDX_W'(1);
          if (pos == IDX_W'(1)) begin
            state_next = ST_LPUT;
          end else begin
            raddr = pos - IDX_W'(2);
          end
        end
      end

      ST_LPUT: begin
        mem_we   = 1'b1;
        waddr    = pos;
        wdata    = item;
        cnt_next = cnt + CNT_W'(1);
        if ((cnt + CNT_W'(1)) >= eff_count) begin
          merging_next = 1'b1;
          state_next   = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_RSCAN: begin
        // rdata holds the entry just below pos.
        mem_we = 1'b1;
        waddr  = pos;
        if (rdata.value > item.value) begin
          wdata    = rdata;
          pos_next = pos + IDX_W'(1);
          if (({1'b0, pos} + CNT_W'(2)) < cnt) begin
            raddr = pos + IDX_W'(2);
          end else begin
            state_next = ST_RPUT;
          end
        end else begin
          wdata      = item;
          state_next = ST_EMIT;
        end
      end

      ST_RPUT: begin
        mem_we     = 1'b1;
        waddr      = pos;
        wdata      = item;
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      merging <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      merging <= merging_next;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    pos  <= pos_next;
    item <= item_next;
  end

  // Output register; a beat waits here while the next item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (top.value == '0) begin
        merged_value <= '0;
        source_list  <= '0;
        done_res     <= 1'b1;
      end else begin
        merged_value <= top.value;
        source_list  <= top.src;
        done_res     <= 1'b0;
      end
    end
  end

  // Checks on the sequencer.
  `ASSERT_ALWAYS(a_cnt_range, cnt <= CNT_W'(MAX_LISTS), "head count above capacity")
  `ASSERT_IMPLIES(a_merge_nonempty, merging, cnt != '0, "merging with no heads held")
  `ASSERT_IMPLIES(a_done_zero, out_valid && done_res,
                  (merged_value == '0) && (source_list == '0), "done beat carries data")
  `ASSERT_NEXT(a_scan_writes, (state == ST_LSCAN) || (state == ST_RSCAN),
               (state != ST_IDLE) || !merging || (cnt != '0), "scan ended without heads")

endmodule

`default_nettype wire
